### rtl/core/address_range_symbol_lookup_defines.svh
// ----------------------------------------------------------------------------
// Address range symbol lookup: assertion macros
// Concurrent assertion wrappers. With SYNTH defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_SYMBOL_LOOKUP_DEFINES_SVH
`define ADDRESS_RANGE_SYMBOL_LOOKUP_DEFINES_SVH

`ifndef SYNTH
// Check an implication at every clock edge outside reset.
`define ARSL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that pre in one cycle is followed by post in the next.
`define ARSL_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ARSL_ASSERT(name, clk, rst, prop, msg)
`define ARSL_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif

`endif

### rtl/core/arsl_pkg.sv
// ----------------------------------------------------------------------------
// Address range symbol lookup: package
// Field widths, codes, the table entry type and the sequencer states.
// ----------------------------------------------------------------------------
package arsl_pkg;

   localparam int DEFAULT_MAX_ENTRIES       = 4096;
   localparam int DEFAULT_MAX_SECTION_COUNT = 16;

   localparam int ADDR_W    = 32;
   localparam int SLOT_W    = 12;
   localparam int SECTION_W = 8;
   localparam int ECOUNT_W  = 13;
   localparam int SCOUNT_W  = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = ECOUNT_W;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_NOT_FOUND = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_READY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENTRY_COUNT   = 1'b0,
      CSR_SECTION_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_PROBE = 2'd1,
      S_CMP   = 2'd2,
      S_DONE  = 2'd3
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    start;
      logic [ADDR_W-1:0]    size;
      logic [ADDR_W-1:0]    name;
      logic [SECTION_W-1:0] section;
   } entry_type;

endpackage

### rtl/core/arsl_if.sv
// ----------------------------------------------------------------------------
// Address range symbol lookup: channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface arsl_req_if import arsl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [SLOT_W-1:0]    entry_index;
   logic [ADDR_W-1:0]    entry_start;
   logic [ADDR_W-1:0]    entry_size;
   logic [ADDR_W-1:0]    entry_name_offset;
   logic [SECTION_W-1:0] entry_section;
   logic [ADDR_W-1:0]    query_address;

   modport source (
      output valid, operation, entry_index, entry_start, entry_size,
             entry_name_offset, entry_section, query_address,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, entry_start, entry_size,
             entry_name_offset, entry_section, query_address,
      output ready
   );
endinterface

interface arsl_rsp_if import arsl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [SLOT_W-1:0]    match_index;
   logic [ADDR_W-1:0]    match_start;
   logic [ADDR_W-1:0]    match_size;
   logic [ADDR_W-1:0]    name_offset;
   logic [SECTION_W-1:0] section_id;
   logic                 section_known;
   logic [ADDR_W-1:0]    offset_in_symbol;

   modport source (
      output valid, status, match_index, match_start, match_size, name_offset,
             section_id, section_known, offset_in_symbol,
      input  ready
   );
   modport sink (
      input  valid, status, match_index, match_start, match_size, name_offset,
             section_id, section_known, offset_in_symbol,
      output ready
   );
endinterface

### rtl/core/arsl_table.sv
// ----------------------------------------------------------------------------
// Address range symbol lookup: entry table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arsl_table import arsl_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
   input  entry_type                      wr_entry,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output entry_type                      rd_entry
);

   entry_type mem_ff [MAX_ENTRIES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

### rtl/core/address_range_symbol_lookup.sv
// ----------------------------------------------------------------------------
// Address range symbol lookup: top level
// Sorted symbol table with a binary floor search and an extent check.
// ----------------------------------------------------------------------------
// A load transfer writes one table entry in the cycle it is accepted and
// returns nothing. A lookup transfer runs a binary search over the first
// entry_count entries through one registered table read port: each probe
// issues the read, then compares and narrows the interval; a lookup makes
// at most floor(log2(entry_count)) + 1 probes. A lookup with bad counts skips
// the search and goes to the done state. The request side is ready only in
// the idle state; a finished response waits in the output register while
// the next request is taken. The table has no reset; only entries that
// were loaded may be looked up.
module address_range_symbol_lookup import arsl_pkg::*; #(
   parameter int MAX_ENTRIES       = DEFAULT_MAX_ENTRIES,
   parameter int MAX_SECTION_COUNT = DEFAULT_MAX_SECTION_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   arsl_req_if.sink              req_chan,
   arsl_rsp_if.source            rsp_chan
);

`include "address_range_symbol_lookup_defines.svh"

   // Table address width and search bound width (bound reaches the count).
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // Configuration registers
   logic [ECOUNT_W-1:0] entry_count_ff;
   logic [SCOUNT_W-1:0] section_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         section_count_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENTRY_COUNT:   entry_count_ff   <= csr_wdata;
            CSR_SECTION_COUNT: section_count_ff <= SCOUNT_W'(csr_wdata);
         endcase
      end
   end

   // Sequencer and search state
   state_type         state_ff, state_in;
   logic [CW-1:0]     lo_ff, lo_in;      // lowest candidate
   logic [CW-1:0]     hi_ff, hi_in;      // one past the highest candidate
   logic [CW-1:0]     mid_ff, mid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              found_vld_ff, found_vld_in;
   logic [AW-1:0]     found_idx_ff, found_idx_in;
   entry_type         found_ff, found_in;
   logic              not_ready_ff, not_ready_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_index_ff;
   logic [ADDR_W-1:0]    rsp_start_ff;
   logic [ADDR_W-1:0]    rsp_size_ff;
   logic [ADDR_W-1:0]    rsp_name_ff;
   logic [SECTION_W-1:0] rsp_section_ff;
   logic                 rsp_known_ff;
   logic [ADDR_W-1:0]    rsp_offset_ff;

   logic          req_ready;
   logic          rsp_load;
   logic          tbl_we;
   logic [AW-1:0] tbl_rd_addr;
   entry_type     tbl_wr_entry;
   entry_type     tbl_rd_entry;
   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid_calc;
   logic          counts_bad;
   logic          slot_ok;
   logic [ADDR_W:0] extent_end;
   logic          hit;

   // Not-ready condition: empty or oversized entry or section count.
   assign counts_bad = (entry_count_ff == '0)
                    || (32'(entry_count_ff) > 32'(MAX_ENTRIES))
                    || (section_count_ff == '0)
                    || (32'(section_count_ff) > 32'(MAX_SECTION_COUNT));

   // Drop loads to slots beyond the table.
   assign slot_ok = 32'(req_chan.entry_index) < 32'(MAX_ENTRIES);

   // Midpoint of [lo, hi - 1], rounded down; only used while lo < hi.
   assign mid_sum  = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - (CW+1)'(1);
   assign mid_calc = mid_sum[CW:1];

   assign tbl_rd_addr = mid_calc[AW-1:0];
   assign tbl_wr_entry = '{start:   req_chan.entry_start,
                           size:    req_chan.entry_size,
                           name:    req_chan.entry_name_offset,
                           section: req_chan.entry_section};

   arsl_table #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_table (
      .clock    (clock),
      .wr_en    (tbl_we),
      .wr_addr  (AW'(req_chan.entry_index)),
      .wr_entry (tbl_wr_entry),
      .rd_addr  (tbl_rd_addr),
      .rd_entry (tbl_rd_entry)
   );

   // Extent check in 33 bits so start + size never wraps.
   assign extent_end = {1'b0, found_ff.start} + {1'b0, found_ff.size};
   assign hit = !not_ready_ff && found_vld_ff && ({1'b0, addr_ff} < extent_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      addr_in      = addr_ff;
      found_vld_in = found_vld_ff;
      found_idx_in = found_idx_ff;
      found_in     = found_ff;
      not_ready_in = not_ready_ff;
      req_ready    = 1'b0;
      tbl_we       = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.operation == OP_LOOKUP) begin
                  addr_in      = req_chan.query_address;
                  lo_in        = '0;
                  hi_in        = CW'(entry_count_ff);
                  found_vld_in = 1'b0;
                  not_ready_in = counts_bad;
                  state_in     = counts_bad ? S_DONE : S_PROBE;
               end else begin
                  tbl_we = slot_ok;
               end
            end
         end
         S_PROBE: begin
            // Issue the read at the midpoint, or finish once the interval is empty.
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = S_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CMP: begin
            // Keep the latest entry at or below the address and move up; else move down.
            if (tbl_rd_entry.start <= addr_ff) begin
               found_vld_in = 1'b1;
               found_idx_in = mid_ff[AW-1:0];
               found_in     = tbl_rd_entry;
               lo_in        = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_PROBE;
         end
         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      addr_ff      <= addr_in;
      found_vld_ff <= found_vld_in;
      found_idx_ff <= found_idx_in;
      found_ff     <= found_in;
      not_ready_ff <= not_ready_in;
   end

   // Response valid: set on load, clear once the transfer completes.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (hit) begin
            rsp_status_ff  <= STATUS_FOUND;
            rsp_index_ff   <= SLOT_W'(found_idx_ff);
            rsp_start_ff   <= found_ff.start;
            rsp_size_ff    <= found_ff.size;
            rsp_name_ff    <= found_ff.name;
            rsp_section_ff <= found_ff.section;
            rsp_known_ff   <= found_ff.section < SECTION_W'(section_count_ff);
            rsp_offset_ff  <= addr_ff - found_ff.start;
         end else begin
            rsp_status_ff  <= not_ready_ff ? STATUS_NOT_READY : STATUS_NOT_FOUND;
            rsp_index_ff   <= '0;
            rsp_start_ff   <= '0;
            rsp_size_ff    <= '0;
            rsp_name_ff    <= '0;
            rsp_section_ff <= '0;
            rsp_known_ff   <= 1'b0;
            rsp_offset_ff  <= '0;
         end
      end
   end

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.match_index      = rsp_index_ff;
   assign rsp_chan.match_start      = rsp_start_ff;
   assign rsp_chan.match_size       = rsp_size_ff;
   assign rsp_chan.name_offset      = rsp_name_ff;
   assign rsp_chan.section_id       = rsp_section_ff;
   assign rsp_chan.section_known    = rsp_known_ff;
   assign rsp_chan.offset_in_symbol = rsp_offset_ff;

   // Assertions
   `ARSL_ASSERT(a_busy_not_ready, clock, reset, (state_ff != S_IDLE) |-> !req_chan.ready, "request taken while busy")
   `ARSL_ASSERT(a_bounds_ordered, clock, reset, (state_ff == S_PROBE) |-> ((lo_ff <= hi_ff) && (hi_ff <= CW'(entry_count_ff))), "search bounds out of order")
   `ARSL_ASSERT_NEXT(a_interval_shrinks, clock, reset, state_ff == S_CMP, (hi_ff - lo_ff) < $past(hi_ff - lo_ff), "search interval did not shrink")
   `ARSL_ASSERT(a_found_inside, clock, reset, (rsp_chan.valid && (rsp_chan.status == STATUS_FOUND)) |-> (rsp_chan.offset_in_symbol < rsp_chan.match_size), "found offset beyond symbol size")
   `ARSL_ASSERT(a_miss_zero, clock, reset, (rsp_chan.valid && (rsp_chan.status != STATUS_FOUND)) |-> ((rsp_chan.match_start == '0) && (rsp_chan.offset_in_symbol == '0) && !rsp_chan.section_known), "miss response carries data")

endmodule
